FILE: rtl/plist_pkg.sv
// Shared types and constants for the positional list engine.
package plist_pkg;

   // Width of one stored entry handle
   localparam int HANDLE_W = 16;
   // Number of cells whose selected values are OR-ed into one group register
   localparam int GROUP_SIZE = 32;

   typedef enum logic [2:0] {
      OP_APPEND = 3'd0,
      OP_INSERT = 3'd1,
      OP_REMOVE = 3'd2,
      OP_READ   = 3'd3,
      OP_CLEAR  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_EXEC   = 2'd1,
      PH_REDUCE = 2'd2
   } phase_type;

   // Broadcast shift controls for the cell row
   typedef struct packed {
      logic ins_en;
      logic rem_en;
   } cell_ctrl_type;

endpackage

FILE: rtl/plist_cell.sv
// One slot cell of the list row: holds a handle and shifts with its neighbors.
module plist_cell #(
   parameter int IW    = 6,
   parameter int INDEX = 0
) (
   input  logic                               clock,
   input  plist_pkg::cell_ctrl_type           ctrl,
   input  logic [IW-1:0]                      at,
   input  logic [plist_pkg::HANDLE_W-1:0]     handle,
   input  logic [plist_pkg::HANDLE_W-1:0]     left_value,
   input  logic [plist_pkg::HANDLE_W-1:0]     right_value,
   output logic [plist_pkg::HANDLE_W-1:0]     value,
   output logic [plist_pkg::HANDLE_W-1:0]     sel_value
);

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

   logic [plist_pkg::HANDLE_W-1:0] value_ff;
   logic [plist_pkg::HANDLE_W-1:0] value_in;
   logic                           hit;
   logic                           above;

   assign hit   = (at == MY_IDX);
   assign above = (MY_IDX > at);

   // Next slot value: insert opens a gap at the target, remove closes it
   always_comb begin
      value_in = value_ff;
      if (ctrl.ins_en) begin
         if (hit) begin
            value_in = handle;
         end else if (above) begin
            value_in = left_value;
         end
      end else if (ctrl.rem_en) begin
         if (hit || above) begin
            value_in = right_value;
         end
      end
   end

   // Slot register, payload only
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   // Contribution to the read-out OR tree
   assign sel_value = hit ? value_ff : '0;

endmodule

FILE: rtl/positional_list_engine_top.sv
// Top level of the positional list engine: control, cell row and read-out tree.
//
// Usage: the block holds an ordered list of up to CAPACITY 16-bit handles.
// A request is transferred at a rising edge where start is high and busy is
// low; req_operation selects append, insert, remove, read or clear, with
// req_position (signed) and req_entry_handle as operands. Each request gives
// exactly one response: rsp_valid is high for one cycle while
// rsp_entry_value, rsp_status and rsp_entry_count hold the result, and the
// response is transferred at the edge that ends that cycle.
// Sequence: the request edge leads into the execute step, then the reduce
// step, then the response cycle that carries the strobe. busy is high during
// execute and reduce, and a new request may be transferred in the cycle
// that carries the previous response strobe, so a new request is taken only
// once the previous one has reached its response cycle. Execute is a shift
// of the whole cell row with a per-group OR of the selected cell; reduce is
// a final OR across the groups into the response register.
// Reset (synchronous, active high) empties the list and drops any response
// in flight; slot contents are not cleared. The receiver cannot stall:
// every response is shown once and is lost if not taken.
module positional_list_engine_top #(
   parameter int CAPACITY = 64,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [2:0]                         req_operation,
   input  logic signed [7:0]                  req_position,
   input  logic [plist_pkg::HANDLE_W-1:0]     req_entry_handle,
   output logic                               rsp_valid,
   output logic [plist_pkg::HANDLE_W-1:0]     rsp_entry_value,
   output logic [1:0]                         rsp_status,
   output logic [CW-1:0]                      rsp_entry_count
);

   localparam int IW      = $clog2(CAPACITY);
   localparam int NGROUPS = (CAPACITY + plist_pkg::GROUP_SIZE - 1) / plist_pkg::GROUP_SIZE;
   localparam int NPAD    = NGROUPS * plist_pkg::GROUP_SIZE;
   localparam int CMPW    = (CW > 8) ? CW : 8;
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   // Request capture
   plist_pkg::op_type              op_ff;
   logic signed [7:0]              pos_ff;
   logic [plist_pkg::HANDLE_W-1:0] handle_ff;

   // Control state
   plist_pkg::phase_type           phase_ff;
   plist_pkg::phase_type           phase_in;
   logic [CW-1:0]                  count_ff;
   logic [CW-1:0]                  count_in;
   plist_pkg::status_type          status_ff;
   plist_pkg::status_type          status_in;
   logic                           give_value_ff;
   logic                           give_value_in;
   logic                           rsp_valid_ff;
   logic [plist_pkg::HANDLE_W-1:0] rsp_value_ff;
   logic [plist_pkg::HANDLE_W-1:0] rsp_value_in;

   // Decode results
   plist_pkg::cell_ctrl_type       ctrl;
   logic [IW-1:0]                  at;
   logic                           full;
   logic                           in_range;
   logic                           pos_lt_count;
   logic [CMPW-1:0]                pos_ext;
   logic [CMPW-1:0]                count_ext;
   logic                           accept;

   // Cell row and read-out tree
   logic [plist_pkg::HANDLE_W-1:0] cell_value [CAPACITY];
   logic [plist_pkg::HANDLE_W-1:0] cell_sel   [NPAD];
   logic [plist_pkg::HANDLE_W-1:0] group_or_ff [NGROUPS];
   logic [plist_pkg::HANDLE_W-1:0] group_or_in [NGROUPS];

   assign accept = start && !busy;
   assign busy   = (phase_ff != plist_pkg::PH_IDLE);

   // Position compare against the held count
   assign pos_ext      = CMPW'(pos_ff[6:0]);
   assign count_ext    = CMPW'(count_ff);
   assign pos_lt_count = !pos_ff[7] && (pos_ext < count_ext);
   assign full         = (count_ff == CAP_COUNT);

   // Operation decode: shift controls, target slot, status and next count
   always_comb begin
      ctrl          = '0;
      at            = IW'(count_ff);
      in_range      = 1'b0;
      count_in      = count_ff;
      status_in     = plist_pkg::ST_DONE;
      give_value_in = 1'b0;
      case (op_ff)
         plist_pkg::OP_APPEND, plist_pkg::OP_INSERT: begin
            if (op_ff == plist_pkg::OP_INSERT) begin
               if (pos_ff[7]) begin
                  at = '0;
               end else if (pos_lt_count) begin
                  at = IW'(pos_ff[6:0]);
               end
            end
            if (full) begin
               status_in = plist_pkg::ST_FULL;
            end else begin
               ctrl.ins_en = 1'b1;
               count_in    = count_ff + CW'(1);
            end
         end
         plist_pkg::OP_REMOVE, plist_pkg::OP_READ: begin
            at       = IW'(pos_ff[6:0]);
            in_range = pos_lt_count;
            if (!in_range) begin
               status_in = plist_pkg::ST_RANGE;
            end else begin
               give_value_in = 1'b1;
               if (op_ff == plist_pkg::OP_REMOVE) begin
                  ctrl.rem_en = 1'b1;
                  count_in    = count_ff - CW'(1);
               end
            end
         end
         plist_pkg::OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
      // Cells move only during the execute cycle
      if (phase_ff != plist_pkg::PH_EXEC) begin
         ctrl = '0;
      end
   end

   // Row of slot cells, each fed by its neighbors
   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [plist_pkg::HANDLE_W-1:0] left_v;
         logic [plist_pkg::HANDLE_W-1:0] right_v;
         if (gi == 0) begin : g_first
            assign left_v = handle_ff;
         end else begin : g_mid_l
            assign left_v = cell_value[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign right_v = '0;
         end else begin : g_mid_r
            assign right_v = cell_value[gi+1];
         end
         plist_cell #(
            .IW    (IW),
            .INDEX (gi)
         ) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .at          (at),
            .handle      (handle_ff),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_value[gi]),
            .sel_value   (cell_sel[gi])
         );
      end
      for (gi = CAPACITY; gi < NPAD; gi++) begin : g_pad
         assign cell_sel[gi] = '0;
      end
   endgenerate

   // First level of read-out: OR of the selected cell within each group
   generate
      for (gi = 0; gi < NGROUPS; gi++) begin : g_group
         always_comb begin
            group_or_in[gi] = '0;
            for (int j = 0; j < plist_pkg::GROUP_SIZE; j++) begin
               group_or_in[gi] = group_or_in[gi] | cell_sel[gi*plist_pkg::GROUP_SIZE + j];
            end
         end
         always_ff @(posedge clock) begin
            if (phase_ff == plist_pkg::PH_EXEC) begin
               group_or_ff[gi] <= group_or_in[gi];
            end
         end
      end
   endgenerate

   // Second level of read-out: OR across groups, gated by the value flag of a read or remove
   always_comb begin
      rsp_value_in = '0;
      for (int g = 0; g < NGROUPS; g++) begin
         rsp_value_in = rsp_value_in | group_or_ff[g];
      end
      if (!give_value_ff) begin
         rsp_value_in = '0;
      end
   end

   // Sequencer next state
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         plist_pkg::PH_IDLE: begin
            if (start) begin
               phase_in = plist_pkg::PH_EXEC;
            end
         end
         plist_pkg::PH_EXEC: begin
            phase_in = plist_pkg::PH_REDUCE;
         end
         plist_pkg::PH_REDUCE: begin
            phase_in = plist_pkg::PH_IDLE;
         end
         default: begin
            phase_in = plist_pkg::PH_IDLE;
         end
      endcase
   end

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= plist_pkg::PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Control registers: count and response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (phase_ff == plist_pkg::PH_EXEC) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= (phase_ff == plist_pkg::PH_REDUCE);
      end
   end

   // Payload registers: request capture, status and response value
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= plist_pkg::op_type'(req_operation);
         pos_ff    <= req_position;
         handle_ff <= req_entry_handle;
      end
      if (phase_ff == plist_pkg::PH_EXEC) begin
         status_ff     <= status_in;
         give_value_ff <= give_value_in;
      end
      if (phase_ff == plist_pkg::PH_REDUCE) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_ff;

   // A response strobe only follows the reduce cycle
   a_strobe_after_reduce: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(phase_ff) == plist_pkg::PH_REDUCE))
      else $error("response strobe without reduce cycle");

   // The held count never exceeds the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("held count above capacity");

   // A refused insert is only reported on a full list
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == plist_pkg::ST_FULL)) |-> (count_ff == CAP_COUNT))
      else $error("full status with room left");

   // Any non-done response carries a zero value
   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != plist_pkg::ST_DONE)) |-> (rsp_value_ff == '0))
      else $error("nonzero value on failed request");

   // A transferred request enters the execute cycle next
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (phase_ff == plist_pkg::PH_EXEC))
      else $error("accepted request not executed");

endmodule

FILE: test/positional_list_checker.sv
`timescale 1ns / 100ps
// Checker for the positional list engine: list predictor and response compare.
module positional_list_checker #(
   parameter int CAPACITY = 64,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic [2:0]                     req_operation,
   input  logic signed [7:0]              req_position,
   input  logic [plist_pkg::HANDLE_W-1:0] req_entry_handle,
   input  logic                           rsp_valid,
   input  logic [plist_pkg::HANDLE_W-1:0] rsp_entry_value,
   input  logic [1:0]                     rsp_status,
   input  logic [CW-1:0]                  rsp_entry_count,
   output int                             failures,
   output int                             outstanding
);

   typedef struct packed {
      logic [plist_pkg::HANDLE_W-1:0] value;
      plist_pkg::status_type          status;
      logic [CW-1:0]                  count;
   } list_reply_type;

   // Shadow copy of the list
   logic [plist_pkg::HANDLE_W-1:0] shadow_slots [CAPACITY];
   int                             shadow_count;
   list_reply_type                 reply_q [$];

   // Apply one request to the shadow list and return the reply it should give
   function automatic list_reply_type apply_request(logic [2:0] op_bits, int pos,
                                                    logic [plist_pkg::HANDLE_W-1:0] handle);
      list_reply_type r;
      int             at;
      int             i;
      r.value  = '0;
      r.status = plist_pkg::ST_DONE;
      case (op_bits)
         plist_pkg::OP_APPEND, plist_pkg::OP_INSERT: begin
            if (shadow_count >= CAPACITY) begin
               r.status = plist_pkg::ST_FULL;
            end else begin
               at = shadow_count;
               // insert clamps: negative goes to the head, past the end appends
               if (op_bits == plist_pkg::OP_INSERT && pos < shadow_count) begin
                  at = (pos < 0) ? 0 : pos;
               end
               for (i = shadow_count; i > at; i--) begin
                  shadow_slots[i] = shadow_slots[i - 1];
               end
               shadow_slots[at] = handle;
               shadow_count++;
            end
         end
         plist_pkg::OP_REMOVE, plist_pkg::OP_READ: begin
            if (pos < 0 || pos >= shadow_count) begin
               r.status = plist_pkg::ST_RANGE;
            end else begin
               r.value = shadow_slots[pos];
               if (op_bits == plist_pkg::OP_REMOVE) begin
                  for (i = pos; i < shadow_count - 1; i++) begin
                     shadow_slots[i] = shadow_slots[i + 1];
                  end
                  shadow_count--;
               end
            end
         end
         plist_pkg::OP_CLEAR: begin
            shadow_count = 0;
         end
         default: ;  // unused codes leave the list alone
      endcase
      r.count = CW'(shadow_count);
      return r;
   endfunction

   task automatic report_mismatch(string note);
      $display("%t list check: %s", $time, note);
      failures++;
   endtask

   // Compare the response transfer first, then queue the new request's reply
   always @(posedge clock) begin
      list_reply_type want;
      if (reset) begin
         reply_q.delete();
         shadow_count = 0;
      end else begin
         if (rsp_valid) begin
            if (reply_q.size() == 0) begin
               report_mismatch("response transfer with no request pending");
            end else begin
               want = reply_q.pop_front();
               if (rsp_entry_value !== want.value)
                  report_mismatch($sformatf("entry_value %h, expected %h",
                                            rsp_entry_value, want.value));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               if (rsp_entry_count !== want.count)
                  report_mismatch($sformatf("entry_count %0d, expected %0d",
                                            rsp_entry_count, want.count));
            end
         end
         if (start && !busy) begin
            reply_q.push_back(apply_request(req_operation, int'(req_position),
                                            req_entry_handle));
         end
      end
      outstanding <= reply_q.size();
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Testbench top for the positional list engine: clock, reset, request stimulus and verdict.
module testbench;

   localparam int LIST_CAP     = 64;
   localparam int CW           = $clog2(LIST_CAP + 1);
   localparam int RANDOM_ITEMS = 850;
   localparam int PHASES       = 6;
   localparam int MAX_GAP      = 20;

   typedef enum int { MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_NOISE } mix_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic [2:0]                     req_operation = '0;
   logic signed [7:0]              req_position = '0;
   logic [plist_pkg::HANDLE_W-1:0] req_entry_handle = '0;
   logic                           rsp_valid;
   logic [plist_pkg::HANDLE_W-1:0] rsp_entry_value;
   logic [1:0]                     rsp_status;
   logic [CW-1:0]                  rsp_entry_count;
   int                             failures;
   int                             outstanding;
   // stimulus-side entry count, used only to aim positions
   int                             list_fill = 0;

   always #2 clock = ~clock;

   positional_list_engine_top #(.CAPACITY(LIST_CAP)) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_position     (req_position),
      .req_entry_handle (req_entry_handle),
      .rsp_valid        (rsp_valid),
      .rsp_entry_value  (rsp_entry_value),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count)
   );

   positional_list_checker #(.CAPACITY(LIST_CAP)) list_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_position     (req_position),
      .req_entry_handle (req_entry_handle),
      .rsp_valid        (rsp_valid),
      .rsp_entry_value  (rsp_entry_value),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .failures         (failures),
      .outstanding      (outstanding)
   );

   // Drive one request and hold it until the transfer edge
   task automatic send_request(logic [2:0] op_bits, logic [7:0] pos,
                               logic [plist_pkg::HANDLE_W-1:0] handle);
      start            <= 1'b1;
      req_operation    <= op_bits;
      req_position     <= pos;
      req_entry_handle <= handle;
      do @(posedge clock); while (busy);
      case (op_bits)
         plist_pkg::OP_APPEND, plist_pkg::OP_INSERT: if (list_fill < LIST_CAP) list_fill++;
         plist_pkg::OP_REMOVE:
            if ($signed(pos) >= 0 && $signed(pos) < list_fill) list_fill--;
         plist_pkg::OP_CLEAR: list_fill = 0;
         default: ;
      endcase
   endtask

   // Random number of idle cycles before the next request
   task automatic sender_gap(int idle_pct);
      int n;
      n = 0;
      while (n < MAX_GAP && $urandom_range(99) < idle_pct) n++;
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Hold off until every pending response has come back
   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [plist_pkg::HANDLE_W-1:0] pick_handle();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return plist_pkg::HANDLE_W'($urandom_range(65535));
      endcase
   endfunction

   // Mostly in-range positions, with some anywhere in the signed range
   function automatic logic [7:0] pick_position(logic [2:0] op_bits);
      if ($urandom_range(4) == 0) return 8'($urandom_range(255));
      if (op_bits == plist_pkg::OP_INSERT) return 8'($urandom_range(list_fill));
      if (list_fill == 0) return 8'($urandom_range(255));
      return 8'($urandom_range(list_fill - 1));
   endfunction

   function automatic logic [2:0] pick_operation(mix_type mix);
      int w;
      w = $urandom_range(99);
      case (mix)
         MIX_FILL:
            return w < 45 ? plist_pkg::OP_APPEND : w < 90 ? plist_pkg::OP_INSERT :
                   w < 95 ? plist_pkg::OP_READ : plist_pkg::OP_REMOVE;
         MIX_DRAIN:
            return w < 55 ? plist_pkg::OP_REMOVE : w < 85 ? plist_pkg::OP_READ :
                   w < 98 ? plist_pkg::OP_INSERT : plist_pkg::OP_CLEAR;
         MIX_BALANCED:
            return w < 25 ? plist_pkg::OP_APPEND : w < 50 ? plist_pkg::OP_INSERT :
                   w < 75 ? plist_pkg::OP_REMOVE : w < 97 ? plist_pkg::OP_READ :
                   plist_pkg::OP_CLEAR;
         default:
            return 3'($urandom_range(7));
      endcase
   endfunction

   initial begin
      mix_type    mix;
      int         burst_left;
      int         sent;
      int         idle_pct;
      int         w;
      logic [2:0] op_bits;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty list, clamps, range edges, unused codes, clear
      send_request(plist_pkg::OP_READ,   8'd0,   16'h0000);   // read on empty
      send_request(plist_pkg::OP_REMOVE, 8'd0,   16'h0000);   // remove on empty
      send_request(plist_pkg::OP_APPEND, 8'd0,   16'hFFFF);
      send_request(plist_pkg::OP_APPEND, 8'h80,  16'h0000);
      send_request(plist_pkg::OP_INSERT, 8'h80,  16'h1234);   // -128 clamps to head
      send_request(plist_pkg::OP_INSERT, 8'd127, 16'hA5A5);   // past the end appends
      send_request(plist_pkg::OP_INSERT, 8'd2,   16'h5A5A);
      send_request(plist_pkg::OP_READ,   8'hFF,  16'hFFFF);   // -1 out of range
      send_request(plist_pkg::OP_READ,   8'd5,   16'h0000);   // one past the end
      send_request(plist_pkg::OP_READ,   8'd4,   16'h0000);
      send_request(plist_pkg::OP_READ,   8'd0,   16'h0000);
      send_request(plist_pkg::OP_REMOVE, 8'd2,   16'h0000);
      send_request(plist_pkg::OP_REMOVE, 8'h80,  16'h0000);
      send_request(plist_pkg::OP_REMOVE, 8'd127, 16'hFFFF);
      send_request(3'd5,                 8'h55,  16'hAAAA);   // unused codes do nothing
      send_request(3'd6,                 8'hAA,  16'h5555);
      send_request(3'd7,                 8'hFF,  16'hFFFF);
      send_request(plist_pkg::OP_REMOVE, 8'd0,   16'h0000);
      send_request(plist_pkg::OP_REMOVE, 8'd2,   16'h0000);   // last entry
      send_request(plist_pkg::OP_CLEAR,  8'd0,   16'h0000);
      send_request(plist_pkg::OP_READ,   8'd0,   16'h0000);   // read after clear
      send_request(plist_pkg::OP_CLEAR,  8'd0,   16'h0000);   // clear on empty
      drain_responses();

      // Random: bursts of fill, drain, balanced and noise traffic per phase
      sent       = 0;
      burst_left = 0;
      mix        = MIX_BALANCED;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 3)
            0: idle_pct = 0;
            1: idle_pct = 65;
            default: idle_pct = 30;
         endcase
         while (sent < (phase + 1) * RANDOM_ITEMS / PHASES) begin
            if (burst_left == 0) begin
               w          = $urandom_range(9);
               mix        = w < 4 ? MIX_FILL : w < 6 ? MIX_DRAIN : w < 9 ? MIX_BALANCED
                                                                     : MIX_NOISE;
               burst_left = $urandom_range(10, 80);
            end
            op_bits = pick_operation(mix);
            sender_gap(idle_pct);
            send_request(op_bits, pick_position(op_bits), pick_handle());
            if (op_bits <= plist_pkg::OP_CLEAR) sent++;
            burst_left--;
         end
         drain_responses();
      end

      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("[positional_list_engine_top] OK");
      end else begin
         $display("[positional_list_engine_top] ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("[positional_list_engine_top] ERROR");
      $finish;
   end

endmodule
